FILE: rtl/ipss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 to seven-segment package
// Shared types, segment codes and decimal helpers for the display run.
// ----------------------------------------------------------------------------
package ipss_pkg;

	localparam int IPSS_QUEUE_DEPTH = 2;

	localparam logic [7:0] IPSS_BLANK   = 8'hFF;
	localparam logic [7:0] IPSS_DP_MASK = 8'h7F;

	// Digits of one octet, most significant first; start is the first shown digit
	typedef struct packed {
		logic [1:0] start;
		logic [3:0] hun;
		logic [3:0] ten;
		logic [3:0] one;
	} octet_dig_t;

	typedef struct packed {
		logic             wlan;
		octet_dig_t [3:0] oct;
	} item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_WORD,
		PH_OCT,
		PH_TRAIL
	} phase_t;

	function automatic logic [7:0] digit_code(input logic [3:0] d);
		logic [7:0] c;
		unique case (d)
			4'd0: c = 8'hC0;
			4'd1: c = 8'hF9;
			4'd2: c = 8'hA4;
			4'd3: c = 8'hB0;
			4'd4: c = 8'h99;
			4'd5: c = 8'h92;
			4'd6: c = 8'h82;
			4'd7: c = 8'hF8;
			4'd8: c = 8'h80;
			4'd9: c = 8'h90;
			default: c = IPSS_BLANK;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] word_code(input logic wlan, input logic [1:0] idx);
		logic [7:0] c;
		if (wlan) begin
			unique case (idx)
				2'd0: c = 8'h8A;
				2'd1: c = 8'hCF;
				2'd2: c = 8'h88;
				2'd3: c = 8'hAB;
				default: c = IPSS_BLANK;
			endcase
		end else begin
			unique case (idx)
				2'd0: c = 8'h86;
				2'd1: c = 8'h87;
				2'd2: c = 8'h8B;
				default: c = IPSS_BLANK;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: rtl/ip_address_to_seven_segment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 address to seven-segment display run
// Turns an interface byte and four address octets into a run of active-low
// seven-segment codes.
// ----------------------------------------------------------------------------
// Each address transaction yields 13 to 22 codes: three blanks, "wlan" or
// "eth", the octets in decimal with a point after the first three, and three
// blanks, the final one flagged by last_code. Codes leave at one per cycle
// from the sequencer's output register while out_stall is low, and a queued
// item follows the final code of the one before without a gap; a sequencer
// that was idle first loads the item. The front end splits octets into
// digits as it accepts them; the queue holds up to QueueDepth items ahead.
module ip_address_to_seven_segment #(
	parameter int QueueDepth = ipss_pkg::IPSS_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] interface_kind,
	input  logic [7:0] octet_first,
	input  logic [7:0] octet_second,
	input  logic [7:0] octet_third,
	input  logic [7:0] octet_fourth,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] segment_code,
	output logic       last_code
);
	import ipss_pkg::*;

	q_status_t q_status;
	item_t     push_item;
	item_t     head_item;
	logic      push;
	logic      pop;

	ipss_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.interface_kind (interface_kind),
		.octet_first    (octet_first),
		.octet_second   (octet_second),
		.octet_third    (octet_third),
		.octet_fourth   (octet_fourth),
		.q_status       (q_status),
		.push           (push),
		.push_item      (push_item)
	);

	ipss_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	ipss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segment_code (segment_code),
		.last_code    (last_code)
	);

	// a run always ends on a blank
	a_last_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_code |-> segment_code == IPSS_BLANK)
		else $error("last code of run is not blank");

	// a new run starts with a blank
	a_run_starts_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_code |=> !out_valid || segment_code == IPSS_BLANK)
		else $error("run does not start with blank");

	// no decimal point on the final code of a run
	a_dp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !segment_code[7] |-> !last_code)
		else $error("decimal point on final code");

endmodule

FILE: rtl/ipss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 to seven-segment front end
// Takes the address transaction, splits each octet into decimal digits and
// marks how many digits are shown.
// ----------------------------------------------------------------------------
module ipss_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         interface_kind,
	input  logic [7:0]         octet_first,
	input  logic [7:0]         octet_second,
	input  logic [7:0]         octet_third,
	input  logic [7:0]         octet_fourth,
	input  ipss_pkg::q_status_t q_status,
	output logic               push,
	output ipss_pkg::item_t    push_item
);
	import ipss_pkg::*;

	function automatic octet_dig_t split_octet(input logic [7:0] v);
		octet_dig_t r;
		logic [6:0]  rem;
		logic [14:0] prod;
		logic [6:0]  tens_x10;
		logic [6:0]  ones;
		if (v >= 8'd200) begin
			r.hun = 4'd2;
			rem   = 7'(v - 8'd200);
		end else if (v >= 8'd100) begin
			r.hun = 4'd1;
			rem   = 7'(v - 8'd100);
		end else begin
			r.hun = 4'd0;
			rem   = v[6:0];
		end
		// rem / 10 by reciprocal, exact for rem below 100
		prod     = 15'(rem) * 15'd205;
		r.ten    = prod[14:11];
		tens_x10 = 7'({3'd0, r.ten} * 7'd10);
		ones     = rem - tens_x10;
		r.one    = ones[3:0];
		if (v >= 8'd100)
			r.start = 2'd0;
		else if (v >= 8'd10)
			r.start = 2'd1;
		else
			r.start = 2'd2;
		return r;
	endfunction

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		push_item.wlan   = (interface_kind == 8'd1);
		push_item.oct[0] = split_octet(octet_first);
		push_item.oct[1] = split_octet(octet_second);
		push_item.oct[2] = split_octet(octet_third);
		push_item.oct[3] = split_octet(octet_fourth);
	end

endmodule

FILE: rtl/ipss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 to seven-segment item queue
// Short register queue between front end and sequencer.
// ----------------------------------------------------------------------------
module ipss_queue #(
	parameter int Depth = ipss_pkg::IPSS_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ipss_pkg::item_t     push_item,
	input  logic                pop,
	output ipss_pkg::item_t     head_item,
	output ipss_pkg::q_status_t q_status
);
	import ipss_pkg::*;

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == CntW'(Depth));
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: rtl/ipss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 to seven-segment sequencer
// Walks one queued item through blanks, interface word, octet digits and
// trailing blanks, one code per cycle to the output register when not stalled.
// ----------------------------------------------------------------------------
module ipss_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ipss_pkg::item_t     head_item,
	input  ipss_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          segment_code,
	output logic                last_code
);
	import ipss_pkg::*;

	item_t      cur_q;
	logic       busy_q;
	phase_t     phase_q, phase_d;
	logic [1:0] sub_q, sub_d;
	logic [1:0] oct_q, oct_d;
	logic [1:0] dig_q, dig_d;
	logic       run_end;
	logic [7:0] code;
	logic       out_valid_q;
	logic [7:0] seg_q;
	logic       last_q;
	logic       out_free;
	logic       advance;
	logic       load;
	octet_dig_t cur_oct;
	logic [3:0] cur_digit;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = busy_q && out_free;
	// next item is taken in the cycle the final code is registered, or when idle
	assign load     = !q_status.empty && (!busy_q || (advance && run_end));
	assign pop      = load;

	assign cur_oct  = cur_q.oct[oct_q];

	// next state
	always_comb begin
		phase_d = phase_q;
		sub_d   = sub_q;
		oct_d   = oct_q;
		dig_d   = dig_q;
		run_end = 1'b0;
		unique case (phase_q)
			PH_LEAD: begin
				sub_d = sub_q + 1'b1;
				if (sub_q == 2'd2) begin
					phase_d = PH_WORD;
					sub_d   = 2'd0;
				end
			end
			PH_WORD: begin
				sub_d = sub_q + 1'b1;
				if (sub_q == (cur_q.wlan ? 2'd3 : 2'd2)) begin
					phase_d = PH_OCT;
					oct_d   = 2'd0;
					dig_d   = cur_q.oct[0].start;
				end
			end
			PH_OCT: begin
				dig_d = dig_q + 1'b1;
				if (dig_q == 2'd2) begin
					if (oct_q == 2'd3) begin
						phase_d = PH_TRAIL;
						sub_d   = 2'd0;
					end else begin
						oct_d = oct_q + 1'b1;
						dig_d = cur_q.oct[oct_q + 2'd1].start;
					end
				end
			end
			PH_TRAIL: begin
				sub_d = sub_q + 1'b1;
				if (sub_q == 2'd2)
					run_end = 1'b1;
			end
			default: ;
		endcase
	end

	// code for the current position
	always_comb begin
		unique case (dig_q)
			2'd0:    cur_digit = cur_oct.hun;
			2'd1:    cur_digit = cur_oct.ten;
			default: cur_digit = cur_oct.one;
		endcase
		unique case (phase_q)
			PH_LEAD:  code = IPSS_BLANK;
			PH_WORD:  code = word_code(cur_q.wlan, sub_q);
			PH_OCT: begin
				code = digit_code(cur_digit);
				if (dig_q == 2'd2 && oct_q != 2'd3)
					code = code & IPSS_DP_MASK;
			end
			PH_TRAIL: code = IPSS_BLANK;
			default:  code = IPSS_BLANK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= head_item;
		if (advance) begin
			seg_q  <= code;
			last_q <= run_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_LEAD;
			sub_q       <= 2'd0;
			oct_q       <= 2'd0;
			dig_q       <= 2'd0;
		end else begin
			if (out_free)
				out_valid_q <= busy_q;
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= PH_LEAD;
				sub_q   <= 2'd0;
				oct_q   <= 2'd0;
				dig_q   <= 2'd0;
			end else if (advance) begin
				if (run_end)
					busy_q <= 1'b0;
				phase_q <= phase_d;
				sub_q   <= sub_d;
				oct_q   <= oct_d;
				dig_q   <= dig_d;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign segment_code = seg_q;
	assign last_code    = last_q;

endmodule

FILE: dv/tb_ip_address_to_seven_segment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the IPv4 address to seven-segment run
// Drives address transactions through the input handshake, predicts the full
// code run of each one (blanks, interface word, dotted decimal octets, blanks)
// and checks every output code and its last flag in order, under several
// mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_ip_address_to_seven_segment;
	import ipss_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int DRAIN_CYCLES = 30;

	// interface word letters, active low
	localparam logic [7:0] SEG_W = 8'h8A;
	localparam logic [7:0] SEG_L = 8'hCF;
	localparam logic [7:0] SEG_A = 8'h88;
	localparam logic [7:0] SEG_N = 8'hAB;
	localparam logic [7:0] SEG_E = 8'h86;
	localparam logic [7:0] SEG_T = 8'h87;
	localparam logic [7:0] SEG_H = 8'h8B;
	localparam logic [7:0] KIND_WLAN = 8'd1;

	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] oct1;
		logic [7:0] oct2;
		logic [7:0] oct3;
		logic [7:0] oct4;
	} addr_item_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] interface_kind;
	logic [7:0] octet_first;
	logic [7:0] octet_second;
	logic [7:0] octet_third;
	logic [7:0] octet_fourth;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] segment_code;
	logic       last_code;

	addr_item_t addr_pending[$];
	addr_item_t addr_cur;
	logic [7:0] seg_due[$];
	bit         last_due[$];
	bit         in_taken;
	int         src_idle_pct;
	int         sink_stall_pct;
	int         error_count;

	ip_address_to_seven_segment i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.interface_kind (interface_kind),
		.octet_first    (octet_first),
		.octet_second   (octet_second),
		.octet_third    (octet_third),
		.octet_fourth   (octet_fourth),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.segment_code   (segment_code),
		.last_code      (last_code)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [7:0] digit_seg(input int d);
		logic [7:0] c;
		case (d)
			0: c = 8'hC0;
			1: c = 8'hF9;
			2: c = 8'hA4;
			3: c = 8'hB0;
			4: c = 8'h99;
			5: c = 8'h92;
			6: c = 8'h82;
			7: c = 8'hF8;
			8: c = 8'h80;
			default: c = 8'h90;
		endcase
		return c;
	endfunction

	task automatic push_seg(input logic [7:0] code, input bit is_last);
		seg_due.push_back(code);
		last_due.push_back(is_last);
	endtask

	// decimal without leading zeros; the point is merged into the units digit
	task automatic push_octet_digits(input logic [7:0] v, input bit with_point);
		int n;
		logic [7:0] units;
		n = int'(v);
		units = digit_seg(n % 10);
		if (n >= 100) push_seg(digit_seg(n / 100), 1'b0);
		if (n >= 10) push_seg(digit_seg((n / 10) % 10), 1'b0);
		if (with_point) units = units & IPSS_DP_MASK;
		push_seg(units, 1'b0);
	endtask

	task automatic predict_run(input addr_item_t it);
		repeat (3) push_seg(IPSS_BLANK, 1'b0);
		if (it.kind == KIND_WLAN) begin
			push_seg(SEG_W, 1'b0);
			push_seg(SEG_L, 1'b0);
			push_seg(SEG_A, 1'b0);
			push_seg(SEG_N, 1'b0);
		end else begin
			push_seg(SEG_E, 1'b0);
			push_seg(SEG_T, 1'b0);
			push_seg(SEG_H, 1'b0);
		end
		push_octet_digits(it.oct1, 1'b1);
		push_octet_digits(it.oct2, 1'b1);
		push_octet_digits(it.oct3, 1'b1);
		push_octet_digits(it.oct4, 1'b0);
		push_seg(IPSS_BLANK, 1'b0);
		push_seg(IPSS_BLANK, 1'b0);
		push_seg(IPSS_BLANK, 1'b1);
	endtask

	// Driver: present a new transaction only once the previous one has gone
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (addr_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				addr_cur = addr_pending.pop_front();
				in_valid       <= 1'b1;
				interface_kind <= addr_cur.kind;
				octet_first    <= addr_cur.oct1;
				octet_second   <= addr_cur.oct2;
				octet_third    <= addr_cur.oct3;
				octet_fourth   <= addr_cur.oct4;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Monitor: check outgoing codes first, then log the accepted address
	always @(posedge clk) begin
		in_taken <= in_valid && (in_stall === 1'b0);
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (seg_due.size() == 0) begin
				$display("%0t: unexpected code seg=%h last=%b", $time, segment_code,
					last_code);
				error_count++;
			end else begin
				if (segment_code !== seg_due[0]) begin
					$display("%0t: segment_code expected %h got %h", $time, seg_due[0],
						segment_code);
					error_count++;
				end
				if (last_code !== last_due[0]) begin
					$display("%0t: last_code expected %b got %b", $time, last_due[0],
						last_code);
					error_count++;
				end
				void'(seg_due.pop_front());
				void'(last_due.pop_front());
			end
		end
		if (arst_n && in_valid && in_stall === 1'b0)
			predict_run('{interface_kind, octet_first, octet_second, octet_third,
				octet_fourth});
	end

	function automatic logic [7:0] rand_octet();
		logic [7:0] v;
		case ($urandom_range(5))
			0: v = 8'($urandom_range(9));
			1: v = 8'($urandom_range(99, 10));
			2, 3: v = 8'($urandom_range(255, 100));
			4: v = $urandom_range(1) ? 8'd0 : 8'd255;
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [7:0] rand_kind();
		logic [7:0] k;
		case ($urandom_range(9))
			0, 1, 2, 3: k = KIND_WLAN;
			4: k = 8'd0;
			default: k = 8'($urandom);
		endcase
		return k;
	endfunction

	task automatic add_addr(input logic [7:0] k, input logic [7:0] a,
		input logic [7:0] b, input logic [7:0] c, input logic [7:0] d);
		addr_pending.push_back('{k, a, b, c, d});
	endtask

	// sender holds off until every code of the phase has come out
	task automatic wait_drained();
		while (addr_pending.size() != 0 || in_valid) @(posedge clk);
		while (seg_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int ph;
		int idle_src[4];
		int idle_sink[4];
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_taken       = 1'b0;
		interface_kind = 8'd0;
		octet_first    = 8'd0;
		octet_second   = 8'd0;
		octet_third    = 8'd0;
		octet_fourth   = 8'd0;
		out_stall      = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		error_count    = 0;
		idle_src  = '{0, 64, 0, 34};
		idle_sink = '{0, 0, 64, 34};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: zeros, all-255 (longest run), word selection edges, digit widths
		add_addr(KIND_WLAN, 8'd0, 8'd0, 8'd0, 8'd0);
		add_addr(KIND_WLAN, 8'd255, 8'd255, 8'd255, 8'd255);
		add_addr(8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
		add_addr(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		add_addr(8'd2, 8'd192, 8'd168, 8'd1, 8'd10);
		add_addr(8'd255, 8'd10, 8'd0, 8'd99, 8'd100);
		add_addr(8'd254, 8'd9, 8'd10, 8'd100, 8'd0);
		add_addr(8'd129, 8'd127, 8'd128, 8'd200, 8'd201);
		add_addr(KIND_WLAN, 8'd12, 8'd34, 8'd56, 8'd78);
		add_addr(KIND_WLAN, 8'd90, 8'd123, 8'd45, 8'd67);
		add_addr(8'd3, 8'd1, 8'd2, 8'd3, 8'd4);
		add_addr(8'd17, 8'd5, 8'd6, 8'd7, 8'd8);
		add_addr(8'd85, 8'd9, 8'd19, 8'd199, 8'd209);
		add_addr(8'd170, 8'd250, 8'd101, 8'd110, 8'd111);
		add_addr(KIND_WLAN, 8'd0, 8'd255, 8'd0, 8'd255);
		add_addr(8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			src_idle_pct   = idle_src[ph];
			sink_stall_pct = idle_sink[ph];
			repeat (80) add_addr(rand_kind(), rand_octet(), rand_octet(), rand_octet(),
				rand_octet());
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_ip_address_to_seven_segment OK");
		end else begin
			$display("tb_ip_address_to_seven_segment NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_ip_address_to_seven_segment NOT OK");
		$finish;
	end

endmodule
